>>> src/bcld_pkg.sv
// Shared types and constants for the button click and long-press detector.
// Used by every module of the block; depends on nothing else.
package bcld_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W     = 3;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 2;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LVL  = 2'd3;

    // Per-key state machine states.
    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_DEBOUNCE = 2'd1,
        ST_SHORT    = 2'd2,
        ST_LONG     = 2'd3
    } key_state_t;

    // Reported events.
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_LSTART = 3'd3,
        EV_LEND   = 3'd4
    } event_t;

    // One classified scan word as it travels from front to back.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              pressed;
        logic              in_range;
        logic [TIME_W-1:0] now;
    } scan_t;

    // Stored record of one key.
    typedef struct packed {
        key_state_t        st;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
        event_t            prior_ev;
    } key_rec_t;

    localparam key_rec_t KEY_REC_RESET = '{
        st:            ST_RELEASED,
        press_stamp:   '0,
        release_stamp: '0,
        prior_ev:      EV_NONE
    };

    // Timing thresholds handed from the configuration registers to the back part.
    typedef struct packed {
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] double_click_ms;
    } timing_t;

endpackage

>>> src/button_click_long_press_detector_top.sv
// Top level of the button click and long-press detector.
// Depends on bcld_pkg, bcld_front, bcld_fifo and bcld_back.
//
// The block takes one scan word per clock while the output side is ready and
// returns exactly one result word per scan word, in order. Each word passes a
// classify register, a two-entry queue, a record read stage and an output
// register, in that order. The back part reads a key record into a register
// and updates it from that copy, with a forwarding path when consecutive words
// hit the same key. Thresholds must be written through the configuration port
// only while the block is idle; the block itself does not enforce this. Per-key
// records start in the released state with zero time stamps right after reset.
module button_click_long_press_detector_top #(
    parameter int NUM_KEYS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [bcld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcld_pkg::MS_W-1:0]       cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bcld_pkg::KEY_W-1:0]      key_index,
    input  logic                            pin_level,
    input  logic [bcld_pkg::TIME_W-1:0]     now_ms,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bcld_pkg::KEY_W-1:0]      key_out,
    output logic [2:0]                      event_code,
    output logic [1:0]                      fsm_state
);

    logic [bcld_pkg::MS_W-1:0] debounce_ms_reg;
    logic [bcld_pkg::MS_W-1:0] long_press_ms_reg;
    logic [bcld_pkg::MS_W-1:0] double_click_ms_reg;
    logic                      pressed_level_reg;
    bcld_pkg::timing_t         timing;

    logic            fq_valid;
    logic            fq_ready;
    bcld_pkg::scan_t fq_item;
    logic            qb_valid;
    logic            qb_ready;
    bcld_pkg::scan_t qb_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg     <= 16'd20;
            long_press_ms_reg   <= 16'd1000;
            double_click_ms_reg <= 16'd300;
            pressed_level_reg   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bcld_pkg::CFG_DEBOUNCE:     debounce_ms_reg     <= cfg_wdata;
                bcld_pkg::CFG_LONG_PRESS:   long_press_ms_reg   <= cfg_wdata;
                bcld_pkg::CFG_DOUBLE_CLICK: double_click_ms_reg <= cfg_wdata;
                bcld_pkg::CFG_PRESSED_LVL:  pressed_level_reg   <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign timing.debounce_ms     = debounce_ms_reg;
    assign timing.long_press_ms   = long_press_ms_reg;
    assign timing.double_click_ms = double_click_ms_reg;

    // Front part: accept and classify.
    bcld_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_index     (key_index),
        .pin_level     (pin_level),
        .now_ms        (now_ms),
        .pressed_level (pressed_level_reg),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_item        (fq_item)
    );

    // Queue between the two parts.
    bcld_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    // Back part: record update and result.
    bcld_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .timing     (timing),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_out    (key_out),
        .event_code (event_code),
        .fsm_state  (fsm_state)
    );

endmodule

>>> src/bcld_front.sv
// Front part: takes scan words, decodes the pressed level and the key range.
// Depends on bcld_pkg.
module bcld_front #(
    parameter int NUM_KEYS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bcld_pkg::KEY_W-1:0] key_index,
    input  logic                       pin_level,
    input  logic [bcld_pkg::TIME_W-1:0] now_ms,
    input  logic                       pressed_level,
    output logic                       q_valid,
    input  logic                       q_ready,
    output bcld_pkg::scan_t            q_item
);

    logic            valid_reg;
    bcld_pkg::scan_t item_reg;
    bcld_pkg::scan_t item_next;

    // The stage takes a new word when it is empty or its word moves on.
    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    // Classify the incoming word.
    always_comb
    begin
        item_next.key      = key_index;
        item_next.pressed  = (pin_level == pressed_level);
        item_next.in_range = (32'(key_index) < 32'(NUM_KEYS));
        item_next.now      = now_ms;
    end

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

>>> src/bcld_fifo.sv
// Short queue of classified scan words between the front and back parts.
// Depends on bcld_pkg.
module bcld_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  bcld_pkg::scan_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output bcld_pkg::scan_t pop_item
);

    localparam int DEPTH = bcld_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcld_pkg::scan_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Occupancy after this cycle.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/bcld_back.sv
// Back part: per-key record memory, state machine update and output register.
// Depends on bcld_pkg.
module bcld_back #(
    parameter int NUM_KEYS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bcld_pkg::timing_t           timing,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  bcld_pkg::scan_t             pop_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bcld_pkg::KEY_W-1:0]  key_out,
    output logic [2:0]                  event_code,
    output logic [1:0]                  fsm_state
);

    localparam int KEY_W  = bcld_pkg::KEY_W;
    localparam int TIME_W = bcld_pkg::TIME_W;
    localparam int MS_W   = bcld_pkg::MS_W;
    localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // Key record memory and its per-entry written flags.
    bcld_pkg::key_rec_t rec_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] written_reg;

    // Update stage.
    logic               b_valid_reg;
    bcld_pkg::scan_t    b_item_reg;
    bcld_pkg::key_rec_t rdata_reg;
    logic               rvld_reg;
    logic               byp_reg;
    bcld_pkg::key_rec_t byp_rec_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [KEY_W-1:0]     key_out_reg;
    bcld_pkg::event_t     event_reg;
    bcld_pkg::key_state_t state_reg;

    logic                         b_adv;
    logic                         load;
    logic                         mem_we;
    logic                         same_key;
    logic [KEY_W+ADDR_W-1:0]      b_key_ext;
    logic [KEY_W+ADDR_W-1:0]      h_key_ext;
    logic [ADDR_W-1:0]            b_addr;
    logic [ADDR_W-1:0]            h_addr;
    bcld_pkg::key_rec_t           rec_cur;
    bcld_pkg::key_rec_t           rec_new;
    bcld_pkg::key_state_t         st_new;
    bcld_pkg::event_t             ev;
    bcld_pkg::key_state_t         res_state;
    bcld_pkg::event_t             res_event;
    logic [TIME_W-1:0]            elapsed;
    logic [TIME_W-1:0]            gap;
    logic                         deb_over;
    logic                         long_over;
    logic                         dc_ok;

    // Handshake between the queue, the update stage and the output register.
    assign b_adv     = b_valid_reg && (!out_valid_reg || out_ready);
    assign pop_ready = !b_valid_reg || b_adv;
    assign load      = pop_valid && pop_ready;
    assign mem_we    = b_adv && b_item_reg.in_range;

    // Memory addresses from key numbers.
    assign b_key_ext = {{ADDR_W{1'b0}}, b_item_reg.key};
    assign h_key_ext = {{ADDR_W{1'b0}}, pop_item.key};
    assign b_addr    = b_key_ext[ADDR_W-1:0];
    assign h_addr    = h_key_ext[ADDR_W-1:0];
    assign same_key  = (pop_item.key == b_item_reg.key);

    // Current record: forwarded write, stored entry, or the reset record.
    always_comb
    begin
        if (byp_reg)
        begin
            rec_cur = byp_rec_reg;
        end
        else if (rvld_reg)
        begin
            rec_cur = rdata_reg;
        end
        else
        begin
            rec_cur = bcld_pkg::KEY_REC_RESET;
        end
    end

    // Wrapping elapsed-time compares.
    assign elapsed   = b_item_reg.now - rec_cur.press_stamp;
    assign gap       = rec_cur.press_stamp - rec_cur.release_stamp;
    assign deb_over  = elapsed > {{(TIME_W - MS_W){1'b0}}, timing.debounce_ms};
    assign long_over = elapsed > {{(TIME_W - MS_W){1'b0}}, timing.long_press_ms};
    assign dc_ok     = gap <= {{(TIME_W - MS_W){1'b0}}, timing.double_click_ms};

    // Per-key state machine step.
    always_comb
    begin
        rec_new = rec_cur;
        st_new  = rec_cur.st;
        ev      = bcld_pkg::EV_NONE;
        case (rec_cur.st)
            bcld_pkg::ST_RELEASED:
            begin
                if (b_item_reg.pressed)
                begin
                    rec_new.press_stamp = b_item_reg.now;
                    st_new = bcld_pkg::ST_DEBOUNCE;
                end
            end
            bcld_pkg::ST_DEBOUNCE:
            begin
                if (!b_item_reg.pressed)
                begin
                    st_new = bcld_pkg::ST_RELEASED;
                end
                else if (deb_over)
                begin
                    st_new = bcld_pkg::ST_SHORT;
                end
            end
            bcld_pkg::ST_SHORT:
            begin
                // The long-press threshold wins over a release in the same word.
                if (long_over)
                begin
                    st_new = bcld_pkg::ST_LONG;
                    ev     = bcld_pkg::EV_LSTART;
                end
                else if (!b_item_reg.pressed)
                begin
                    if (rec_cur.prior_ev == bcld_pkg::EV_SINGLE && dc_ok)
                    begin
                        ev = bcld_pkg::EV_DOUBLE;
                    end
                    else
                    begin
                        ev = bcld_pkg::EV_SINGLE;
                    end
                    rec_new.prior_ev      = ev;
                    rec_new.release_stamp = b_item_reg.now;
                    st_new = bcld_pkg::ST_RELEASED;
                end
            end
            default:
            begin
                if (!b_item_reg.pressed)
                begin
                    ev = bcld_pkg::EV_LEND;
                    rec_new.prior_ev      = ev;
                    rec_new.release_stamp = b_item_reg.now;
                    st_new = bcld_pkg::ST_RELEASED;
                end
            end
        endcase
        rec_new.st = st_new;
    end

    // Keys beyond the configured count report nothing.
    assign res_state = b_item_reg.in_range ? st_new : bcld_pkg::ST_RELEASED;
    assign res_event = b_item_reg.in_range ? ev : bcld_pkg::EV_NONE;

    // Control state of the update stage and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
            rvld_reg      <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (pop_ready)
            begin
                b_valid_reg <= pop_valid;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
            if (mem_we)
            begin
                written_reg[b_addr] <= 1'b1;
            end
            if (load)
            begin
                rvld_reg <= written_reg[h_addr];
                byp_reg  <= mem_we && same_key;
            end
        end
    end

    // Record memory: registered read for the next word, write-back of this one.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            b_item_reg  <= pop_item;
            rdata_reg   <= rec_mem[h_addr];
            byp_rec_reg <= rec_new;
        end
        if (mem_we)
        begin
            rec_mem[b_addr] <= rec_new;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            key_out_reg <= b_item_reg.key;
            event_reg   <= res_event;
            state_reg   <= res_state;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_out    = key_out_reg;
    assign event_code = event_reg;
    assign fsm_state  = state_reg;

    // A key outside the configured range leaves a quiet result.
    a_out_of_range_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && !b_item_reg.in_range) |=>
        (event_code == bcld_pkg::EV_NONE && fsm_state == bcld_pkg::ST_RELEASED))
        else $error("out-of-range key produced an event or state");

    // Long start is only ever reported together with the long pressed state.
    a_lstart_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_code == bcld_pkg::EV_LSTART) |->
        (fsm_state == bcld_pkg::ST_LONG))
        else $error("long start without long pressed state");

    // Click and long-end events always return the key to released.
    a_release_events: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_code == bcld_pkg::EV_SINGLE ||
                       event_code == bcld_pkg::EV_DOUBLE ||
                       event_code == bcld_pkg::EV_LEND)) |->
        (fsm_state == bcld_pkg::ST_RELEASED))
        else $error("release event with a pressed state");

    // A same-key write-back in the load cycle always sets the forwarding flag.
    a_bypass_source: assert property (@(posedge clk) disable iff (!rst_n)
        (load && byp_reg == 1'b0 && mem_we && same_key) |=> byp_reg)
        else $error("missed forwarding of a same-key write-back");

endmodule
